// ===== design/isolated_pixel_counter_top_assert.svh =====
// Assertion macros shared by the isolated pixel counter RTL.
`ifndef ISOLATED_PIXEL_COUNTER_TOP_ASSERT_SVH
`define ISOLATED_PIXEL_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isolated pixel counter: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isolated pixel counter: next-cycle check failed");

`endif

// ===== design/ipc_pkg.sv =====
// Package with the constants, types and helpers of the isolated pixel counter.
package ipc_pkg;

  localparam int MAX_ROWS    = 128;
  localparam int MAX_COLS    = 128;
  localparam int SIZE_W      = 8;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int COUNT_W     = 15;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int LINE_DEPTH  = MAX_COLS - 1;

  localparam logic [SIZE_W-1:0] MAX_ROWS_SZ = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] MAX_COLS_SZ = SIZE_W'(MAX_COLS);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_ROWS = CFG_INDEX_W'(0),
    REG_IMAGE_COLS = CFG_INDEX_W'(1)
  } cfg_reg_t;

  // Star bit and candidate bit of one pixel.
  typedef struct packed {
    logic star;
    logic cand;
  } pix_t;

  // A size of zero counts as one; a size above the maximum saturates.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max_v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/isolated_pixel_counter_top.sv =====
// Isolated pixel counter: one pixel per clock unless stalled, count after the frame's last pixel.
// The count is registered and shown on the output in the cycle after the last pixel is accepted.
// Throughput: one pixel per cycle; input stalls while a configuration write is offered, or
// when a frame ends while the previous count is still waiting to be taken.
// Reset: synchronous, active high; sizes return to one row by one column, frame state clears.
// A configuration write to either size register clears the frame in progress at once.
module isolated_pixel_counter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ipc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           pixel_is_star,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ipc_pkg::COUNT_W-1:0]    isolated_count
);
  import ipc_pkg::*;

  `include "isolated_pixel_counter_top_assert.svh"

  // Frame size registers, held already clamped to their legal range.
  logic [SIZE_W-1:0] image_rows;
  logic [SIZE_W-1:0] image_cols;

  // Raster position of the next pixel.
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;

  // Running count of candidates that have not been killed.
  logic [COUNT_W-1:0] live;
  logic [COUNT_W-1:0] live_next;

  // The line buffer holds the last cols-1 pixels before the previous one. Entry 0 is
  // the pixel straight above the current one, entry 1 the one above and to the right.
  // New pixels enter at entry cols-2 and the whole line moves one place towards entry 0
  // every pixel, so only fixed taps are ever read. The previous pixel waits in prev
  // so that the current pixel can still kill its candidate bit, and the pixel above
  // and to the left is kept in up_left after it leaves the line.
  pix_t line [LINE_DEPTH];
  pix_t line_next [LINE_DEPTH];
  pix_t prev;
  pix_t up_left;

  logic cfg_we;
  logic in_acc;
  logic out_acc;
  logic last_col;
  logic last_pixel;

  logic has_left;
  logic has_right;
  logic cols_is_1;
  logic cols_is_2;
  pix_t up_c;
  pix_t up_r;
  pix_t prev_k;
  pix_t line1_k;
  pix_t up_c_k;
  logic seen;
  logic new_cand;
  logic kill_ul;
  logic kill_uc;
  logic kill_ur;
  logic kill_left;
  logic [2:0] kill_cnt;
  logic [SIZE_W-1:0] ins_idx;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign last_col   = ({1'b0, col_pos} + SIZE_W'(1)) == image_cols;
  assign last_pixel = last_col && (({1'b0, row_pos} + SIZE_W'(1)) == image_rows);

  // A configuration write takes the cycle for itself, so no pixel request is taken beside
  // it. Otherwise only a request that closes a frame needs the output register to be free.
  assign in_stall = cfg_valid || (out_valid && out_stall && last_pixel);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // Neighbourhood test on the fixed taps.
  always_comb begin
    has_left  = col_pos != '0;
    has_right = !last_col;
    cols_is_1 = image_cols == SIZE_W'(1);
    cols_is_2 = image_cols == SIZE_W'(2);

    // With one or two columns the pixel above (or above right) is still in prev.
    up_c = cols_is_1 ? prev : line[0];
    up_r = cols_is_2 ? prev : line[1];

    seen = up_c.star
        || (has_left && (up_left.star || prev.star))
        || (has_right && up_r.star);
    new_cand = pixel_is_star && !seen;

    kill_ul   = pixel_is_star && has_left && up_left.cand;
    kill_uc   = pixel_is_star && up_c.cand;
    kill_ur   = pixel_is_star && has_right && up_r.cand;
    kill_left = pixel_is_star && has_left && prev.cand;
    kill_cnt  = 3'(kill_ul) + 3'(kill_uc) + 3'(kill_ur) + 3'(kill_left);

    prev_k  = prev;
    line1_k = line[1];
    up_c_k  = up_c;
    if (pixel_is_star) begin
      up_c_k.cand = 1'b0;
      if (has_left || cols_is_1 || (cols_is_2 && has_right)) begin
        prev_k.cand = 1'b0;
      end
      if (has_right && !cols_is_2) begin
        line1_k.cand = 1'b0;
      end
    end

    live_next = live + COUNT_W'(new_cand) - COUNT_W'(kill_cnt);

    // Shift the line by one and insert the previous pixel at entry cols-2. With one
    // column the index wraps past the line and nothing is written.
    ins_idx = image_cols - SIZE_W'(2);
    for (int i = 0; i < LINE_DEPTH - 1; i++) begin
      if (ins_idx == SIZE_W'(i)) begin
        line_next[i] = prev_k;
      end else if (i == 0) begin
        line_next[i] = line1_k;
      end else begin
        line_next[i] = line[i+1];
      end
    end
    line_next[LINE_DEPTH-1] = (ins_idx == SIZE_W'(LINE_DEPTH - 1)) ? prev_k
                                                                   : line[LINE_DEPTH-1];
  end

  // Configuration and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= SIZE_W'(1);
      image_cols <= SIZE_W'(1);
      row_pos    <= '0;
      col_pos    <= '0;
      live       <= '0;
      prev       <= '0;
      up_left    <= '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS: image_rows <= clamp_size(cfg_data, MAX_ROWS_SZ);
        REG_IMAGE_COLS: image_cols <= clamp_size(cfg_data, MAX_COLS_SZ);
        default: ;
      endcase
      // A write to either size register drops the frame in progress; a write to an
      // unknown index leaves it alone.
      if (cfg_index == REG_IMAGE_ROWS || cfg_index == REG_IMAGE_COLS) begin
        row_pos <= '0;
        col_pos <= '0;
        live    <= '0;
        prev    <= '0;
        up_left <= '0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
          line[i] <= '0;
        end
      end
    end else if (in_acc) begin
      if (last_pixel) begin
        // End of frame: everything goes back to an empty upper row.
        row_pos <= '0;
        col_pos <= '0;
        live    <= '0;
        prev    <= '0;
        up_left <= '0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
          line[i] <= '0;
        end
      end else begin
        if (last_col) begin
          col_pos <= '0;
          row_pos <= row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
        live         <= live_next;
        prev.star    <= pixel_is_star;
        prev.cand    <= new_cand;
        up_left      <= up_c_k;
        line         <= line_next;
      end
    end
  end

  // Output register: holds the count until it is taken, and can be refilled in the
  // same cycle as it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && last_pixel && !cfg_we) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_pixel && !cfg_we) begin
      isolated_count <= live_next;
    end
  end

  `IPC_ASSERT_IMP(a_col_in_range, 1'b1, {1'b0, col_pos} < image_cols)
  `IPC_ASSERT_IMP(a_row_in_range, 1'b1, {1'b0, row_pos} < image_rows)
  `IPC_ASSERT_NXT(a_frame_end_result, in_acc && last_pixel && !cfg_we, out_valid)
  `IPC_ASSERT_NXT(a_frame_end_clear, in_acc && last_pixel,
                  col_pos == '0 && row_pos == '0 && live == '0)

endmodule

// ===== sim/tb_isolated_pixel_counter_top.sv =====
// Self-checking testbench for the isolated pixel counter: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_isolated_pixel_counter_top;
  import ipc_pkg::*;

  // Clock period, run length and stall settings.
  localparam int HALF_PERIOD = 6;
  localparam int PIXEL_GOAL = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  // An index that names no register; a write to it must leave the frame alone.
  localparam logic [CFG_INDEX_W-1:0] SPARE_REG_INDEX = 8'hFE;

  // Every input of the block holds a known value from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic pixel_is_star = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COUNT_W-1:0] isolated_count;

  isolated_pixel_counter_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_is_star  (pixel_is_star),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .isolated_count (isolated_count)
  );

  always #HALF_PERIOD clk = ~clk;

  // Pixels waiting to be offered, and frame counts the block still owes us.
  logic pending_pixels[$];
  logic [COUNT_W-1:0] expected_counts[$];

  // Idling percentages for the current phase, and the long output holds asked for and begun.
  int sender_gap_pct = 6;
  int recv_stall_pct = 56;
  int long_holds_asked = 0;
  int long_holds_begun = 0;
  int hold_left = 0;

  logic pixel_taken = 1'b0;
  int errors = 0;
  int pixels_queued = 0;
  int pixels_taken = 0;
  int counts_checked = 0;
  int writes_done = 0;
  int held_cycles = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the frame size, the two rows of star and candidate
  // bits and the number of candidates still alive. A star with no star among its four
  // earlier neighbours becomes a candidate; any candidate next to a later star is retired.
  // ---------------------------------------------------------------------------------------
  int frame_rows;
  int frame_cols;
  int row_at;
  int col_at;
  int live_count;
  logic [MAX_COLS-1:0] upper_star;
  logic [MAX_COLS-1:0] row_star;
  logic [MAX_COLS-1:0] upper_cand;
  logic [MAX_COLS-1:0] row_cand;

  function automatic void clear_frame_state();
    upper_star = '0;
    row_star = '0;
    upper_cand = '0;
    row_cand = '0;
    row_at = 0;
    col_at = 0;
    live_count = 0;
  endfunction

  // A size of zero means one; anything beyond the maximum saturates to it.
  function automatic int fit_size(input logic [CFG_DATA_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_ROWS: begin
        frame_rows = fit_size(data, MAX_ROWS);
        clear_frame_state();
      end
      REG_IMAGE_COLS: begin
        frame_cols = fit_size(data, MAX_COLS);
        clear_frame_state();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void predict_pixel(input logic star, output logic done,
                                        output logic [COUNT_W-1:0] count);
    int c;
    logic seen;
    c = (col_at < frame_cols) ? col_at : 0;
    done = 1'b0;
    count = '0;
    if (star) begin
      seen = upper_star[c];
      if (c > 0) seen = seen | upper_star[c-1] | row_star[c-1];
      if (c + 1 < frame_cols) seen = seen | upper_star[c+1];
      // Candidates on the row above that touch this star are no longer isolated.
      for (int k = c - 1; k <= c + 1; k++) begin
        if (k >= 0 && k < frame_cols && upper_cand[k]) begin
          upper_cand[k] = 1'b0;
          if (live_count > 0) live_count--;
        end
      end
      if (c > 0 && row_cand[c-1]) begin
        row_cand[c-1] = 1'b0;
        if (live_count > 0) live_count--;
      end
      row_star[c] = 1'b1;
      row_cand[c] = !seen;
      if (!seen) live_count++;
    end else begin
      row_star[c] = 1'b0;
      row_cand[c] = 1'b0;
    end
    if (c + 1 < frame_cols) begin
      col_at = c + 1;
    end else begin
      col_at = 0;
      if (row_at + 1 < frame_rows) begin
        // The finished row becomes the upper row for the next one.
        row_at++;
        upper_star = row_star;
        upper_cand = row_cand;
        row_star = '0;
        row_cand = '0;
      end else begin
        done = 1'b1;
        count = COUNT_W'((live_count > COUNT_MAX) ? COUNT_MAX : live_count);
        clear_frame_state();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Pixel driver. It changes its outputs on the falling edge, holds a stalled request until
  // it is taken, and otherwise idles at random.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      pixel_is_star <= 1'b0;
    end else if (!in_valid || pixel_taken) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
        in_valid <= 1'b1;
        pixel_is_star <= pending_pixels.pop_front();
      end else begin
        in_valid <= 1'b0;
        pixel_is_star <= 1'($urandom_range(1));
      end
    end
  end

  // Result receiver. A long hold is counted here, so that the block fills up and stalls
  // its pixel input while the driver keeps offering.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_holds_begun != long_holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      long_holds_begun <= long_holds_asked;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor. Everything is sampled on the rising edge: results are checked against the
  // oldest expected count first, then register writes and accepted pixels update the
  // predictor.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    logic [COUNT_W-1:0] want;
    logic [COUNT_W-1:0] new_count;
    logic frame_done;
    if (rst) begin
      frame_rows = 1;
      frame_cols = 1;
      clear_frame_state();
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= in_valid && !in_stall;
      if (in_valid && in_stall) held_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          errors++;
          $display("%0t: unexpected count, expected none, actual %0d", $time, isolated_count);
        end else begin
          want = expected_counts.pop_front();
          counts_checked++;
          if (isolated_count !== want) begin
            errors++;
            $display("%0t: isolated_count mismatch, expected %0d, actual %0d",
                     $time, want, isolated_count);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        pixels_taken++;
        predict_pixel(pixel_is_star, frame_done, new_count);
        if (frame_done) expected_counts = {expected_counts, new_count};
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  // Waits until every queued pixel has been taken and every count has arrived, then lets
  // the output latency pass so that a partly fed frame is settled. Returns on a falling edge.
  task automatic wait_idle();
    do @(posedge clk); while (pending_pixels.size() != 0 || in_valid);
    do @(negedge clk); while (expected_counts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; the caller lowers the valid once its last write is done.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    writes_done++;
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] rows_data,
                          input logic [CFG_DATA_W-1:0] cols_data, input bit both);
    wait_idle();
    if (both) cfg_write(REG_IMAGE_ROWS, rows_data);
    cfg_write(REG_IMAGE_COLS, cols_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pattern(input string bits);
    for (int i = 0; i < bits.len(); i++) begin
      pending_pixels = {pending_pixels, logic'(bits[i] == "1")};
    end
    pixels_queued += bits.len();
  endtask

  task automatic queue_pixels(input int star_pct, input int length);
    for (int i = 0; i < length; i++) begin
      pending_pixels = {pending_pixels, logic'($urandom_range(99) < star_pct)};
    end
    pixels_queued += length;
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int rows_pick;
    int cols_pick;
    logic [CFG_DATA_W-1:0] rows_data;
    logic [CFG_DATA_W-1:0] cols_data;
    int frames;
    int area;
    int phase;
    phase = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // After reset the frame is a single pixel: an empty one, then a lone star.
    queue_pattern("01");

    // A 3x3 frame with stars in the four corners gives four isolated stars. A write to an
    // index that names no register falls in the middle of it and must not disturb it.
    set_size(8'd3, 8'd3, 1'b1);
    queue_pattern("10100");
    wait_idle();
    cfg_write(SPARE_REG_INDEX, 8'hFF);
    cfg_valid <= 1'b0;
    queue_pattern("0101");

    // A frame left half done is thrown away by the next size write. The following 2x3
    // frame has three stars touching along the row and diagonally, so nothing is isolated.
    queue_pattern("110");
    set_size(8'd2, 8'd3, 1'b1);
    queue_pattern("110001");

    // Size extremes: a zero that counts as one, and values at and past the maximum.
    set_size(8'hFF, 8'h00, 1'b1);
    queue_pixels(25, frame_rows * frame_cols);
    set_size(8'h01, 8'h80, 1'b1);
    queue_pixels(25, frame_rows * frame_cols);
    set_size(8'h02, 8'h81, 1'b1);
    queue_pixels(30, frame_rows * frame_cols);

    // Random frames. Mostly small sizes so that counts come often, a few long and thin
    // frames, and now and then a broken frame that the next size write abandons.
    while (pixels_queued < PIXEL_GOAL) begin
      if (phase == 0 && pixels_queued >= PIXEL_GOAL / 3) begin
        phase = 1;
        sender_gap_pct = 56;
        recv_stall_pct = 6;
      end else if (phase == 1 && pixels_queued >= 2 * PIXEL_GOAL / 3) begin
        phase = 2;
        sender_gap_pct = 0;
        recv_stall_pct = 0;
        // Tiny frames back to back against a long output hold fill the block up.
        set_size(8'd2, 8'd2, 1'b1);
        long_holds_asked++;
        for (int f = 0; f < 30; f++) queue_pixels(50, 4);
      end
      if ($urandom_range(99) < 85) begin
        rows_pick = $urandom_range(1, 8);
        cols_pick = $urandom_range(1, 8);
        frames = $urandom_range(1, 4);
      end else if ($urandom_range(1) == 1) begin
        rows_pick = $urandom_range(9, MAX_ROWS);
        cols_pick = $urandom_range(1, 3);
        frames = 1;
      end else begin
        rows_pick = $urandom_range(1, 3);
        cols_pick = $urandom_range(9, MAX_COLS);
        frames = 1;
      end
      rows_data = CFG_DATA_W'(rows_pick);
      cols_data = CFG_DATA_W'(cols_pick);
      if ($urandom_range(99) < 5) begin
        rows_data = ($urandom_range(1) == 1) ? '0 : 8'($urandom_range(129, 255));
      end
      if ($urandom_range(99) < 5) begin
        cols_data = ($urandom_range(1) == 1) ? '0 : 8'($urandom_range(129, 255));
      end
      // Now and then only the column count changes and the row count is kept.
      set_size(rows_data, cols_data, $urandom_range(99) >= 20);
      area = frame_rows * frame_cols;
      for (int f = 0; f < frames; f++) queue_pixels($urandom_range(0, 100), area);
      if (area > 1 && $urandom_range(99) < 25) queue_pixels(50, $urandom_range(1, area - 1));
    end

    wait_idle();
    repeat (8) @(negedge clk);
    $display("covered %0d pixels and %0d frame counts over %0d register writes,",
             pixels_taken, counts_checked, writes_done);
    $display("with the pixel input held back for %0d cycles", held_cycles);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
